/* hw/rtl/rpn_pkg.sv */
`default_nettype none

package rpn_pkg;

    // Operand stack geometry
    localparam int STACK_DEPTH = 32;
    localparam int STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int STACK_CW    = $clog2(STACK_DEPTH + 1);

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Data widths
    localparam int DATA_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int SYM_W      = 8;
    localparam int DIGIT_W    = 4;
    localparam int M_TDATA_W  = 40;
    localparam int DIV_STEPS  = DATA_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // ASCII codes
    localparam logic [SYM_W-1:0] CHAR_0     = 8'h30;
    localparam logic [SYM_W-1:0] CHAR_9     = 8'h39;
    localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CHAR_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CHAR_SLASH = 8'h2F;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OPERANDS = 3'd1;
    localparam logic [STATUS_W-1:0] ST_COUNT    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DIVZERO  = 3'd4;

    localparam logic [DATA_W-1:0] ERR_VALUE = '1;

    // Classified symbol kind
    typedef enum logic [2:0] {
        KIND_NOP,
        KIND_DIGIT,
        KIND_ADD,
        KIND_SUB,
        KIND_MUL,
        KIND_DIV
    } kind_t;

    // Word held in the queue
    typedef struct packed {
        kind_t              kind;
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } item_t;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/postfix_expression_evaluator_unit.sv */
`default_nettype none

// Postfix (RPN) evaluator over a byte stream of ASCII characters, one per word on the
// slave side, s_tlast marking the final character. Digits push, + - * / pop two and push
// the 32-bit wrapping result (division truncates toward zero); other characters are
// ignored. On the last character one word leaves on the master side: the value, or all
// ones with a nonzero status (1 missing operands, 2 final count not one, 3 overflow,
// 4 divide by zero). While the four-deep queue has room, a classifier takes one word per
// cycle into it and drops ignored characters unless they close the expression; the
// executing stage then handles a digit or a closing ignored character on fetch, + - *
// with a further refill step (which refills the next-of-stack register from the
// registered read of the stack memory) and / through the iterative divider (an issuing
// step, one quotient bit per cycle, a sign fix and a done step), then forms the result
// on the last character, waiting while an earlier result word still waits on m_tready.
// The stack contents are not cleared at reset; the block is ready straight after reset.
module postfix_expression_evaluator_unit import rpn_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [SYM_W-1:0]     s_tdata,   // [7:0] symbol
    input  wire logic                 s_tlast,   // last_symbol
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata    // [31:0] value, [34:32] status, rest zero
);

    logic  fifo_push, fifo_pop, fifo_full, fifo_empty;
    item_t push_item, pop_item;

    rpn_front u_front (
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .fifo_full (fifo_full),
        .fifo_push (fifo_push),
        .fifo_item (push_item)
    );

    rpn_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .push_item (push_item),
        .pop       (fifo_pop),
        .pop_item  (pop_item),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    rpn_exec u_exec (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_empty (fifo_empty),
        .fifo_item  (pop_item),
        .fifo_pop   (fifo_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

/* hw/rtl/rpn_front.sv */
`default_nettype none

module rpn_front import rpn_pkg::*; (
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [SYM_W-1:0] s_tdata,   // [7:0] symbol
    input  wire logic             s_tlast,   // last_symbol
    input  wire logic             fifo_full,
    output logic                  fifo_push,
    output item_t                 fifo_item
);

    kind_t kind;

    // Classify the incoming character
    always_comb begin
        if (s_tdata >= CHAR_0 && s_tdata <= CHAR_9) begin
            kind = KIND_DIGIT;
        end else if (s_tdata == CHAR_PLUS) begin
            kind = KIND_ADD;
        end else if (s_tdata == CHAR_MINUS) begin
            kind = KIND_SUB;
        end else if (s_tdata == CHAR_STAR) begin
            kind = KIND_MUL;
        end else if (s_tdata == CHAR_SLASH) begin
            kind = KIND_DIV;
        end else begin
            kind = KIND_NOP;
        end
    end

    // Accept whenever the queue has room; drop ignored characters that do not close a run
    assign s_tready        = aresetn && !fifo_full;
    assign fifo_push       = s_tvalid && s_tready && (kind != KIND_NOP || s_tlast);
    assign fifo_item.kind  = kind;
    assign fifo_item.digit = DIGIT_W'(s_tdata - CHAR_0);
    assign fifo_item.last  = s_tlast;

endmodule

`default_nettype wire

/* hw/rtl/rpn_fifo.sv */
`default_nettype none

module rpn_fifo import rpn_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire item_t push_item,
    input  wire logic  pop,
    output item_t      pop_item,
    output logic       full,
    output logic       empty
);

    item_t              entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign full     = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + FIFO_AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + FIFO_AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + FIFO_CW'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - FIFO_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rpn_div.sv */
`default_nettype none

module rpn_div import rpn_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_FIX
    } dstate_t;

    dstate_t              state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    den_reg, den_next;
    logic                 neg_reg, neg_next;
    logic [DATA_W-1:0]    q_reg, q_next;
    logic                 done_reg, done_next;
    logic [DATA_W:0]      rem_shift;
    logic [DATA_W:0]      diff;

    // One restoring step per cycle
    assign rem_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign diff      = rem_shift - {1'b0, den_reg};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        q_next     = q_reg;
        done_next  = 1'b0;
        case (state_reg)
            D_IDLE: begin
                if (req.start) begin
                    neg_next   = req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
                    quo_next   = req.dividend[DATA_W-1] ? (DATA_W'(0) - req.dividend)
                                                        : req.dividend;
                    den_next   = req.divisor[DATA_W-1] ? (DATA_W'(0) - req.divisor)
                                                       : req.divisor;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = D_RUN;
                end
            end
            D_RUN: begin
                if (!diff[DATA_W]) begin
                    rem_next = diff[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_shift[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = D_FIX;
                end
            end
            D_FIX: begin
                // Apply the sign of the quotient
                q_next     = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default: begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        q_reg   <= q_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

`default_nettype wire

/* hw/rtl/rpn_exec.sv */
`default_nettype none

module rpn_exec import rpn_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 fifo_empty,
    input  wire item_t                fifo_item,
    output logic                      fifo_pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata
);

    typedef enum logic [1:0] {
        S_FETCH,
        S_REFILL,
        S_DIV,
        S_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic [STACK_CW-1:0]   count_reg, count_next;
    logic [STATUS_W-1:0]   error_reg, error_next;
    logic [DATA_W-1:0]     tos_reg, tos_next;
    logic [DATA_W-1:0]     nos_reg, nos_next;
    logic                  last_pend_reg, last_pend_next;
    logic                  m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]     value_reg, value_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [DATA_W-1:0]     rd_reg;
    logic [DATA_W-1:0]     stack_mem [STACK_DEPTH];

    logic [STACK_CW-1:0]   count_m2, count_m3;
    logic [STACK_AW-1:0]   wr_addr, rd_addr;
    logic                  wr_en;
    logic                  out_free;
    logic [DATA_W-1:0]     alu_res;
    div_req_t              div_req;
    div_rsp_t              div_rsp;

    // Entries below the top two live in memory
    assign count_m2 = count_reg - STACK_CW'(2);
    assign count_m3 = count_reg - STACK_CW'(3);
    assign wr_addr  = count_m2[STACK_AW-1:0];
    assign rd_addr  = count_m3[STACK_AW-1:0];
    assign out_free = !m_valid_reg || m_tready;

    // Left operand is next-of-stack, right operand is top-of-stack
    always_comb begin
        case (fifo_item.kind)
            KIND_ADD: alu_res = nos_reg + tos_reg;
            KIND_SUB: alu_res = nos_reg - tos_reg;
            KIND_MUL: alu_res = DATA_W'(nos_reg * tos_reg);
            default:  alu_res = nos_reg + tos_reg;
        endcase
    end

    rpn_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Sequence one queued word at a time
    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        error_next       = error_reg;
        tos_next         = tos_reg;
        nos_next         = nos_reg;
        last_pend_next   = last_pend_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        value_next       = value_reg;
        status_next      = status_reg;
        fifo_pop         = 1'b0;
        wr_en            = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = nos_reg;
        div_req.divisor  = tos_reg;
        case (state_reg)
            S_FETCH: begin
                if (!fifo_empty) begin
                    fifo_pop       = 1'b1;
                    last_pend_next = fifo_item.last;
                    state_next     = fifo_item.last ? S_EMIT : S_FETCH;
                    if (error_reg == ST_OK) begin
                        case (fifo_item.kind)
                            KIND_DIGIT: begin
                                if (count_reg >= STACK_CW'(STACK_DEPTH)) begin
                                    error_next = ST_OVERFLOW;
                                end else begin
                                    wr_en      = (count_reg >= STACK_CW'(2));
                                    nos_next   = tos_reg;
                                    tos_next   = DATA_W'(fifo_item.digit);
                                    count_next = count_reg + STACK_CW'(1);
                                end
                            end
                            KIND_ADD, KIND_SUB, KIND_MUL: begin
                                if (count_reg < STACK_CW'(2)) begin
                                    error_next = ST_OPERANDS;
                                end else begin
                                    tos_next   = alu_res;
                                    count_next = count_reg - STACK_CW'(1);
                                    state_next = S_REFILL;
                                end
                            end
                            KIND_DIV: begin
                                if (count_reg < STACK_CW'(2)) begin
                                    error_next = ST_OPERANDS;
                                end else if (tos_reg == '0) begin
                                    error_next = ST_DIVZERO;
                                end else begin
                                    div_req.start = 1'b1;
                                    state_next    = S_DIV;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_REFILL: begin
                // Pull the new next-of-stack back from memory
                nos_next   = rd_reg;
                state_next = last_pend_reg ? S_EMIT : S_FETCH;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    tos_next   = div_rsp.quotient;
                    nos_next   = rd_reg;
                    count_next = count_reg - STACK_CW'(1);
                    state_next = last_pend_reg ? S_EMIT : S_FETCH;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (error_reg != ST_OK) begin
                        value_next  = ERR_VALUE;
                        status_next = error_reg;
                    end else if (count_reg != STACK_CW'(1)) begin
                        value_next  = ERR_VALUE;
                        status_next = ST_COUNT;
                    end else begin
                        value_next  = tos_reg;
                        status_next = ST_OK;
                    end
                    count_next = '0;
                    error_next = ST_OK;
                    state_next = S_FETCH;
                end
            end
            default: begin
                state_next = S_FETCH;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_FETCH;
            count_reg     <= '0;
            error_reg     <= ST_OK;
            last_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            error_reg     <= error_next;
            last_pend_reg <= last_pend_next;
            m_valid_reg   <= m_valid_next;
        end
        tos_reg    <= tos_next;
        nos_reg    <= nos_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    // Spill next-of-stack on push; read the entry below it every cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= nos_reg;
        end
        rd_reg <= stack_mem[rd_addr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - DATA_W - STATUS_W)'(0), status_reg, value_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= STACK_CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && out_free) |=>
            (count_reg == '0 && error_reg == ST_OK && m_valid_reg))
        else $error("result word not loaded or state not cleared");

    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (error_reg != ST_OK && state_reg != S_EMIT) |=> (error_reg == $past(error_reg)))
        else $error("error code changed before result");

    a_error_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg != ST_OK) |-> (value_reg == ERR_VALUE))
        else $error("failed expression without all-ones value");

endmodule

`default_nettype wire

/* dv/rpn_result_checker.sv */
`timescale 1ns / 100ps

// Watch both channels of the postfix evaluator, predict each result word from the
// accepted characters and compare it with what leaves on the master side.
module rpn_result_checker import rpn_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [SYM_W-1:0]     s_tdata,
    input  wire logic                 s_tlast,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    output int unsigned               fault_count,
    output int unsigned               awaited_count
);

    typedef struct packed {
        logic [DATA_W-1:0]   value;
        logic [STATUS_W-1:0] status;
    } outcome_t;

    // Shadow of the evaluator: operand stack, fill level and first error
    logic [DATA_W-1:0]   shadow_stack [STACK_DEPTH];
    int unsigned         shadow_depth;
    logic [STATUS_W-1:0] shadow_error;

    outcome_t            pending_outcomes [$];
    outcome_t            head;
    outcome_t            formed;
    int unsigned         mismatch_tally;

    // Signed division rounded toward zero, done on magnitudes so that the most
    // negative value over minus one wraps instead of trapping
    function automatic logic [DATA_W-1:0] trunc_quotient(input logic [DATA_W-1:0] num,
                                                         input logic [DATA_W-1:0] den);
        logic [DATA_W-1:0] mag_n;
        logic [DATA_W-1:0] mag_d;
        logic [DATA_W-1:0] q;
        mag_n = num[DATA_W-1] ? (~num + 1'b1) : num;
        mag_d = den[DATA_W-1] ? (~den + 1'b1) : den;
        q     = mag_n / mag_d;
        return (num[DATA_W-1] ^ den[DATA_W-1]) ? (~q + 1'b1) : q;
    endfunction

    // Advance the shadow stack by one character
    function automatic void eval_symbol(input logic [SYM_W-1:0] sym);
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] res;
        if (shadow_error != ST_OK) return;
        if (sym >= CHAR_0 && sym <= CHAR_9) begin
            if (shadow_depth >= STACK_DEPTH) begin
                shadow_error = ST_OVERFLOW;
            end else begin
                shadow_stack[shadow_depth] = DATA_W'(sym - CHAR_0);
                shadow_depth++;
            end
            return;
        end
        if (!(sym inside {CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH})) return;
        if (shadow_depth < 2) begin
            shadow_error = ST_OPERANDS;
            return;
        end
        rhs = shadow_stack[shadow_depth-1];
        lhs = shadow_stack[shadow_depth-2];
        case (sym)
            CHAR_STAR:  res = lhs * rhs;
            CHAR_SLASH: begin
                if (rhs == '0) begin
                    shadow_error = ST_DIVZERO;
                    return;
                end
                res = trunc_quotient(lhs, rhs);
            end
            CHAR_PLUS:  res = lhs + rhs;
            default:    res = lhs - rhs;
        endcase
        shadow_depth--;
        shadow_stack[shadow_depth-1] = res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            shadow_depth   = 0;
            shadow_error   = ST_OK;
            mismatch_tally = 0;
            pending_outcomes.delete();
        end else begin
            // Predict on every accepted character; form the result on the last one
            if (s_tvalid && s_tready) begin
                eval_symbol(s_tdata);
                if (s_tlast) begin
                    if (shadow_error != ST_OK) begin
                        formed.value  = ERR_VALUE;
                        formed.status = shadow_error;
                    end else if (shadow_depth != 1) begin
                        formed.value  = ERR_VALUE;
                        formed.status = ST_COUNT;
                    end else begin
                        formed.value  = shadow_stack[0];
                        formed.status = ST_OK;
                    end
                    pending_outcomes.push_back(formed);
                    shadow_depth = 0;
                    shadow_error = ST_OK;
                end
            end

            // Compare each result word with the oldest prediction
            if (m_tvalid && m_tready) begin
                if (pending_outcomes.size() == 0) begin
                    $error("result word with nothing predicted: value %0d status %0d",
                           $signed(m_tdata[DATA_W-1:0]), m_tdata[DATA_W +: STATUS_W]);
                    mismatch_tally++;
                end else begin
                    head = pending_outcomes.pop_front();
                    if (m_tdata[DATA_W-1:0] !== head.value) begin
                        $error("value: expected %0d, got %0d",
                               $signed(head.value), $signed(m_tdata[DATA_W-1:0]));
                        mismatch_tally++;
                    end
                    if (m_tdata[DATA_W +: STATUS_W] !== head.status) begin
                        $error("status: expected %0d, got %0d",
                               head.status, m_tdata[DATA_W +: STATUS_W]);
                        mismatch_tally++;
                    end
                    if (m_tdata[M_TDATA_W-1:DATA_W+STATUS_W] !== '0) begin
                        $error("padding: expected 0, got %0h",
                               m_tdata[M_TDATA_W-1:DATA_W+STATUS_W]);
                        mismatch_tally++;
                    end
                end
            end
        end
        fault_count   <= mismatch_tally;
        awaited_count <= pending_outcomes.size();
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import rpn_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400_000;
    localparam int unsigned RANDOM_WORDS = 800;
    localparam int unsigned DRAIN_CYCLES = 60;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [SYM_W-1:0]     s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tready = 1'b0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire [M_TDATA_W-1:0]  m_tdata;

    int unsigned          fault_count;
    int unsigned          awaited_count;

    bit                   quiet_phase = 1'b0;
    bit                   tx_bursty   = 1'b1;
    int unsigned          rx_stall    = 0;
    int unsigned          rx_calm     = 0;
    int unsigned          cycle_count = 0;
    int unsigned          words_sent  = 0;
    logic [SYM_W-1:0]     line_q [$];

    postfix_expression_evaluator_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] symbol
        .s_tlast  (s_tlast),    // last_symbol
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // [31:0] value, [34:32] status, rest zero
    );

    rpn_result_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fault_count   (fault_count),
        .awaited_count (awaited_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Throttle the result side: random stall bursts between calm stretches
    always @(negedge aclk) begin
        if (rx_stall != 0) begin
            rx_stall <= rx_stall - 1;
            m_tready <= 1'b0;
        end else if (rx_calm != 0 || quiet_phase) begin
            if (rx_calm != 0) rx_calm <= rx_calm - 1;
            m_tready <= 1'b1;
        end else begin
            rx_stall <= $urandom_range(0, 15);
            rx_calm  <= $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(20, 80);
            m_tready <= 1'b0;
        end
    end

    function automatic bit is_token(input logic [SYM_W-1:0] sym);
        return (sym >= CHAR_0 && sym <= CHAR_9) ||
               (sym inside {CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH});
    endfunction

    function automatic logic [SYM_W-1:0] pick_digit();
        return CHAR_0 + SYM_W'($urandom_range(0, 9));
    endfunction

    function automatic logic [SYM_W-1:0] pick_operator();
        case ($urandom_range(0, 3))
            0:       return CHAR_PLUS;
            1:       return CHAR_MINUS;
            2:       return CHAR_STAR;
            default: return CHAR_SLASH;
        endcase
    endfunction

    function automatic logic [SYM_W-1:0] pick_ignored();
        logic [SYM_W-1:0] sym;
        sym = SYM_W'($urandom_range(0, 255));
        while (is_token(sym)) sym = SYM_W'($urandom_range(0, 255));
        return sym;
    endfunction

    // Present one character, with an optional idle burst first, and hold until taken
    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic fin);
        int unsigned gap;
        gap = 0;
        if (tx_bursty && !quiet_phase && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 16);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = sym;
        s_tlast  = fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_symbol(txt[i], i == txt.len() - 1);
    endtask

    // Send the built expression, marking its final character
    task automatic send_line();
        for (int i = 0; i < line_q.size(); i++) begin
            if (is_token(line_q[i])) words_sent++;
            send_symbol(line_q[i], i == line_q.size() - 1);
        end
    endtask

    // Well-formed expression of nd digits; op_pct steers how early operators reduce
    task automatic build_valid(input int unsigned nd, input int unsigned op_pct);
        int unsigned depth;
        int unsigned left;
        depth = 0;
        left  = nd;
        while (left != 0 || depth > 1) begin
            if ($urandom_range(0, 15) == 0) line_q.push_back(pick_ignored());
            if (depth >= 2 && (left == 0 || $urandom_range(0, 99) < op_pct)) begin
                line_q.push_back(pick_operator());
                depth--;
            end else begin
                line_q.push_back(pick_digit());
                depth++;
                left--;
            end
        end
    endtask

    // Push past a full stack, then trail a few operators that must be skipped
    task automatic build_overflow();
        repeat (STACK_DEPTH + $urandom_range(1, 3)) line_q.push_back(pick_digit());
        repeat ($urandom_range(0, 3)) line_q.push_back(pick_operator());
    endtask

    // Build 8^10 * 2, which wraps to the most negative value, and divide by minus one
    task automatic build_min_quotient();
        line_q.push_back(CHAR_0 + 8'd8);
        repeat (9) begin
            line_q.push_back(CHAR_0 + 8'd8);
            line_q.push_back(CHAR_STAR);
        end
        line_q.push_back(CHAR_0 + 8'd2);
        line_q.push_back(CHAR_STAR);
        line_q.push_back(CHAR_0);
        line_q.push_back(CHAR_0 + 8'd1);
        line_q.push_back(CHAR_MINUS);
        line_q.push_back(CHAR_SLASH);
    endtask

    // Arbitrary mix of tokens and stray bytes, mostly malformed
    task automatic build_noise();
        repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(0, 2))
                0:       line_q.push_back(pick_digit());
                1:       line_q.push_back(pick_operator());
                default: line_q.push_back(SYM_W'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial begin
        int unsigned n_expr;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: single digit, empty expression of extreme bytes, each operator,
        // truncating division of a negative value, missing operands, divide by zero,
        // and characters skipped after an error
        send_text("9");
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'h00, 1'b1);
        send_text("95-");
        send_text("34*");
        send_text("72/");
        send_text("07-2/");
        send_text("+");
        send_text("50/");
        send_text("+95-");

        // Hold off until every directed result has drained
        s_tvalid = 1'b0;
        while (awaited_count != 0) @(negedge aclk);

        // Random expressions: mostly well-formed, some deep, some broken
        n_expr     = 0;
        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            tx_bursty   = $urandom_range(0, 1);
            quiet_phase = words_sent > (RANDOM_WORDS * 7) / 8;
            line_q.delete();
            if (n_expr == 0) begin
                build_overflow();
            end else if (n_expr == 1) begin
                build_min_quotient();
            end else begin
                case ($urandom_range(0, 15))
                    0:       build_overflow();
                    1:       build_min_quotient();
                    2, 3, 4: build_noise();
                    5:       build_valid(STACK_DEPTH, 0);
                    default: build_valid($urandom_range(1, 10), $urandom_range(20, 80));
                endcase
            end
            send_line();
            n_expr++;
        end
        s_tvalid = 1'b0;

        // Drain, then wait out DRAIN_CYCLES for stray words
        while (awaited_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fault_count == 0 && awaited_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/rpn_pkg.sv
hw/rtl/rpn_front.sv
hw/rtl/rpn_fifo.sv
hw/rtl/rpn_div.sv
hw/rtl/rpn_exec.sv
hw/rtl/postfix_expression_evaluator_unit.sv
dv/rpn_result_checker.sv
dv/testbench.sv
